// File: hw/rtl/chained_hash_set_macros.svh
// Assertion helpers for the hash set.
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/chs_pkg.sv
`default_nettype none
package chs_pkg;
  localparam int unsigned NumBucketsDflt = 10;
  localparam int unsigned PoolSizeDflt   = 64;
  localparam int unsigned KeyW           = 31;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_HASH,
    BE_HEAD,
    BE_WALK,
    BE_UNLINK,
    BE_FREE,
    BE_RESULT
  } be_state_e;

  typedef struct packed {
    logic    success;
    status_e status;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/chs_front.sv
`default_nettype none
// Request queue: takes beats and passes them in order to the back end.
module chs_front import chs_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [KeyW-1:0] key_i,
  output logic                 valid_o,
  input  wire logic            take_i,
  output req_e                 req_o,
  output logic [KeyW-1:0]      key_o
);
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [KeyW+1:0] mem_q [Depth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign req_o   = req_e'(mem_q[rp_q][KeyW+1:KeyW]);
  assign key_o   = mem_q[rp_q][KeyW-1:0];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= {req_type_i, key_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == PW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chs_back.sv
`default_nettype none
// Chain walker: bucket heads in flops, node store in memory.
module chs_back import chs_pkg::*; #(
  parameter int unsigned NumBuckets = NumBucketsDflt,
  parameter int unsigned PoolSize   = PoolSizeDflt
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 take_o,
  input  wire req_e            req_i,
  input  wire logic [KeyW-1:0] key_i,
  output logic                 res_valid_o,
  input  wire logic            res_take_i,
  output result_t              res_o
);
  localparam int unsigned PtrW = $clog2(PoolSize + 1);
  localparam int unsigned IdxW = (PoolSize > 1) ? $clog2(PoolSize) : 1;
  localparam int unsigned BW   = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam logic [PtrW-1:0] Nil = PtrW'(PoolSize);

  logic [PtrW-1:0] head_q [NumBuckets];
  logic [KeyW-1:0] nkey_mem [PoolSize];
  logic [PtrW-1:0] nnext_mem [PoolSize];

  be_state_e       st_q, st_d;
  req_e            req_q;
  logic [KeyW-1:0] key_q;
  logic [BW-1:0]   bkt_q;
  logic [PtrW-1:0] cur_q, prev_q, free_q, fresh_q, hnext_q;
  logic [KeyW-1:0] rkey_q;
  logic [PtrW-1:0] rnext_q;
  logic [PtrW:0]   steps_q;
  result_t         res_q;
  logic            rv_q;
  logic            rd_ok_q;
  logic [BW:0]     rem_q;
  logic [1:0]      hstep_q;
  logic            res_free;

  // Bucket = key mod NumBuckets, one key byte per cycle.
  logic [BW:0] rem_d;
  logic [7:0]  kbyte;
  always_comb begin
    logic [31:0] kx;
    kx = {{(32-KeyW){1'b0}}, key_q};
    unique case (hstep_q)
      2'd0:    kbyte = kx[31:24];
      2'd1:    kbyte = kx[23:16];
      2'd2:    kbyte = kx[15:8];
      default: kbyte = kx[7:0];
    endcase
    rem_d = rem_q;
    for (int i = 7; i >= 0; i--) begin
      rem_d = {rem_d[BW-1:0], kbyte[i]};
      if (rem_d >= (BW+1)'(NumBuckets)) rem_d = rem_d - (BW+1)'(NumBuckets);
    end
  end

  logic hit, nil_cur;
  assign nil_cur  = (cur_q >= Nil) || (steps_q >= (PtrW+1)'(PoolSize));
  assign hit      = (rkey_q == key_q);
  assign res_free = !rv_q || res_take_i;

  // Memory write port, driven per state.
  logic            we;
  logic [IdxW-1:0] wa;
  logic [KeyW-1:0] wkey;
  logic            wkey_en;
  logic [PtrW-1:0] wnext;
  logic [IdxW-1:0] ra;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BE_IDLE:   if (valid_i) st_d = BE_HASH;
      BE_HASH:   if (hstep_q == 2'd3) st_d = BE_HEAD;
      BE_HEAD:   st_d = BE_WALK;
      BE_WALK:   if (nil_cur || (rd_ok_q && hit)) st_d = BE_UNLINK;
      BE_UNLINK: st_d = BE_FREE;
      BE_FREE:   st_d = BE_RESULT;
      BE_RESULT: if (res_free) st_d = BE_IDLE;
      default:   st_d = BE_IDLE;
    endcase
  end

  assign take_o      = (st_q == BE_IDLE) && valid_i;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  // Unlink step reads the free-list head so its link is ready for the pop.
  assign ra          = (st_q == BE_UNLINK) ? IdxW'(free_q) : IdxW'(cur_q);

  always_ff @(posedge clk_i) begin
    rkey_q  <= nkey_mem[ra];
    rnext_q <= nnext_mem[ra];
    if (we) begin
      nnext_mem[wa] <= wnext;
      if (wkey_en) nkey_mem[wa] <= wkey;
    end
  end

  logic found_q;
  always_comb begin
    we = 1'b0; wa = '0; wkey = key_q; wkey_en = 1'b0; wnext = '0;
    unique case (st_q)
      BE_UNLINK: begin
        if (req_q == REQ_DELETE && found_q && prev_q != Nil) begin
          we = 1'b1; wa = IdxW'(prev_q); wnext = hnext_q;
        end
      end
      BE_FREE: begin
        if (req_q == REQ_DELETE && found_q) begin
          we = 1'b1; wa = IdxW'(cur_q); wnext = free_q;
        end else if (req_q == REQ_INSERT && !found_q && cur_q != Nil) begin
          we = 1'b1; wa = IdxW'(cur_q); wnext = head_q[bkt_q]; wkey_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      req_q <= req_i;
      key_q <= key_i;
    end
    if (st_q == BE_HASH && hstep_q == 2'd3) bkt_q <= rem_d[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BE_IDLE;
      rv_q    <= 1'b0;
      free_q  <= Nil;
      fresh_q <= '0;
      cur_q   <= Nil;
      prev_q  <= Nil;
      hnext_q <= Nil;
      steps_q <= '0;
      found_q <= 1'b0;
      rd_ok_q <= 1'b0;
      rem_q   <= '0;
      hstep_q <= '0;
      res_q   <= '0;
      for (int i = 0; i < NumBuckets; i++) head_q[i] <= Nil;
    end else begin
      st_q <= st_d;
      if (st_q == BE_RESULT && res_free) rv_q <= 1'b1;
      else if (rv_q && res_take_i)       rv_q <= 1'b0;
      unique case (st_q)
        BE_IDLE: begin
          if (take_o) begin
            rem_q   <= '0;
            hstep_q <= '0;
          end
        end
        BE_HASH: begin
          rem_q   <= rem_d;
          hstep_q <= hstep_q + 1'b1;
        end
        BE_HEAD: begin
          cur_q   <= head_q[bkt_q];
          prev_q  <= Nil;
          steps_q <= '0;
          found_q <= 1'b0;
          rd_ok_q <= 1'b0;
        end
        BE_WALK: begin
          // Read data is registered behind the address: wait for it at each node,
          // then compare and either stop or follow the link.
          if (!rd_ok_q) begin
            rd_ok_q <= 1'b1;
          end else if (!nil_cur && hit) begin
            found_q <= 1'b1;
            hnext_q <= rnext_q;
          end else if (!nil_cur) begin
            prev_q  <= cur_q;
            cur_q   <= rnext_q;
            steps_q <= steps_q + 1'b1;
            rd_ok_q <= 1'b0;
          end
        end
        BE_UNLINK: begin
          if (req_q == REQ_DELETE && found_q && prev_q == Nil) head_q[bkt_q] <= hnext_q;
          if (req_q == REQ_INSERT && !found_q) begin
            if (free_q != Nil) begin
              cur_q <= free_q;
            end else if (fresh_q != Nil) begin
              cur_q   <= fresh_q;
              fresh_q <= fresh_q + 1'b1;
            end else begin
              cur_q <= Nil;
            end
          end
        end
        BE_FREE: begin
          if (req_q == REQ_DELETE && found_q) free_q <= cur_q;
          if (req_q == REQ_INSERT && !found_q && cur_q != Nil) begin
            if (cur_q == free_q) free_q <= rnext_q;
            head_q[bkt_q] <= cur_q;
          end
        end
        BE_RESULT: begin
          if (res_free) begin
            unique case (req_q)
              REQ_INSERT: begin
                if (found_q)           res_q <= '{1'b0, ST_PRESENT};
                else if (cur_q == Nil) res_q <= '{1'b0, ST_FULL};
                else                   res_q <= '{1'b1, ST_DONE};
              end
              REQ_DELETE, REQ_LOOKUP: res_q <= found_q ? '{1'b1, ST_DONE} : '{1'b0, ST_ABSENT};
              default: res_q <= '{1'b0, ST_ABSENT};
            endcase
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chained_hash_set.sv
`default_nettype none
// Hash set with separate chaining. Requests enter a two-beat queue; the back
// end hashes the key one key byte at a time, then walks one chain in node
// memory through the registered read port, node by node, and sees the null
// link when the key is absent. The back end takes one request at a time and
// accepts the next only after the result of the last has been registered.
// A result waiting in the output register stalls the back end only in its
// final step. Bucket heads are flops cleared at reset; node memory needs no
// clear.
`include "chained_hash_set_macros.svh"
module chained_hash_set import chs_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NumBucketsDflt,
  parameter int unsigned POOL_SIZE   = PoolSizeDflt
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [KeyW-1:0] key_i,
  output logic                 empty,
  input  wire logic            pop,
  output logic                 success_o,
  output logic [1:0]           status_o
);
  logic            fe_valid, be_take;
  req_e            fe_req;
  logic [KeyW-1:0] fe_key;
  logic            rv;
  result_t         res;

  chs_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .req_type_i, .key_i, .valid_o(fe_valid), .take_i(be_take),
    .req_o(fe_req), .key_o(fe_key)
  );

  chs_back #(.NumBuckets(NUM_BUCKETS), .PoolSize(POOL_SIZE)) u_back (
    .clk_i, .rst_ni, .valid_i(fe_valid), .take_o(be_take),
    .req_i(fe_req), .key_i(fe_key), .res_valid_o(rv),
    .res_take_i(pop), .res_o(res)
  );

  assign empty     = !rv;
  assign success_o = res.success;
  assign status_o  = res.status;

  // success and status agree on every result beat.
  `CHS_ASSERT_IMP(a_succ_stat, clk_i, rst_ni, !empty, success_o == (status_o == ST_DONE))
  // An unpopped result stays.
  `CHS_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty)
endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
// Testbench for the chained hash set: a scoreboard keeps its own copy of the
// set (bucket heads, node pool, free list) and predicts one result per beat.
module tb_top;
  import chs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NB  = NumBucketsDflt;
  localparam int unsigned PS  = PoolSizeDflt;
  localparam int unsigned NIL = PS;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic    success;
    status_e status;
  } hs_result_t;

  // Predicts the set and holds the results still owed by the block.
  class hash_set_scoreboard;
    int unsigned head_q[NB];
    logic [KeyW-1:0] key_mem[PS];
    int unsigned next_mem[PS];
    int unsigned free_head;
    int unsigned fresh_cnt;
    hs_result_t owed_q[$];
    int unsigned errors;
    int unsigned n_full, n_present, n_absent, n_done;

    function new();
      foreach (head_q[i]) head_q[i] = NIL;
      free_head = NIL;
      fresh_cnt = 0;
      errors = 0;
      n_full = 0; n_present = 0; n_absent = 0; n_done = 0;
    endfunction

    function void note_request(req_e req, logic [KeyW-1:0] key);
      int unsigned b, cur, prev, hit, steps, n;
      hs_result_t r;
      b = key % NB;
      cur = head_q[b];
      prev = NIL;
      hit = NIL;
      steps = 0;
      while (cur < NIL && steps < PS && hit == NIL) begin
        if (key_mem[cur] == key) hit = cur;
        else begin
          prev = cur;
          cur = next_mem[cur];
        end
        steps++;
      end
      if (hit == NIL) prev = NIL;
      r.success = 1'b0;
      r.status = ST_ABSENT;
      case (req)
        REQ_INSERT: begin
          if (hit < NIL) r.status = ST_PRESENT;
          else begin
            n = NIL;
            if (free_head < NIL) begin
              n = free_head;
              free_head = next_mem[n];
            end else if (fresh_cnt < PS) begin
              n = fresh_cnt;
              fresh_cnt++;
            end
            if (n < NIL) begin
              key_mem[n] = key;
              next_mem[n] = head_q[b];
              head_q[b] = n;
              r.success = 1'b1;
              r.status = ST_DONE;
            end else r.status = ST_FULL;
          end
        end
        REQ_DELETE: begin
          if (hit < NIL) begin
            if (prev < NIL) next_mem[prev] = next_mem[hit];
            else head_q[b] = next_mem[hit];
            next_mem[hit] = free_head;
            free_head = hit;
            r.success = 1'b1;
            r.status = ST_DONE;
          end
        end
        REQ_LOOKUP: begin
          if (hit < NIL) begin
            r.success = 1'b1;
            r.status = ST_DONE;
          end
        end
        default: ;
      endcase
      case (r.status)
        ST_FULL: n_full++;
        ST_PRESENT: n_present++;
        ST_ABSENT: n_absent++;
        default: n_done++;
      endcase
      owed_q.push_back(r);
    endfunction

    function void check_result(logic success, logic [1:0] status);
      hs_result_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (success !== e.success) begin
        $error("success: expected %0d actual %0d", e.success, success);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] req_type_i = '0;
  logic [KeyW-1:0] key_i = '0;
  logic full, empty, success_o;
  logic [1:0] status_o;

  hash_set_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned beats_in = 0;

  always #1 clk_i = ~clk_i;

  chained_hash_set u_top (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .key_i,
    .empty, .pop, .success_o, .status_o
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample both handshakes at the rising edge; the scoreboard sees the
  // request first so a same-edge result always finds its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_request(req_e'(req_type_i), key_i);
        beats_in++;
      end
      if (pop && !empty) sb.check_result(success_o, status_o[1:0]);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("chained_hash_set verification failed");
        $finish;
      end
    end
  end

  // Result side: random pop gaps; quiet stretches with pop held high.
  initial begin : result_side
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 7) == 0) begin
        pop <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  // One request beat; push stays high when the next beat follows directly.
  task automatic send_req(req_e req, logic [KeyW-1:0] key, bit no_gap = 0);
    int unsigned g;
    req_type_i <= req;
    key_i <= key;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // Keys mostly from a small range, so chains grow and keys recur.
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return KeyW'($urandom_range(0, 89));
    if (p < 85) return KeyW'($urandom);
    return KeyW'({KeyW{1'b1}} - KeyW'($urandom_range(0, 29)));
  endfunction

  initial begin : stimulus
    int unsigned p;
    bit burst;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, duplicates, absent keys, unused code.
    send_req(REQ_LOOKUP, '0);
    send_req(REQ_DELETE, {KeyW{1'b1}});
    send_req(REQ_INSERT, '0);
    send_req(REQ_INSERT, '0);
    send_req(REQ_INSERT, {KeyW{1'b1}});
    send_req(REQ_LOOKUP, {KeyW{1'b1}});
    send_req(REQ_NONE, {KeyW{1'b1}});
    send_req(REQ_NONE, '0);
    send_req(REQ_INSERT, KeyW'(10));
    send_req(REQ_INSERT, KeyW'(20));
    send_req(REQ_DELETE, KeyW'(10));
    send_req(REQ_LOOKUP, KeyW'(10));
    send_req(REQ_LOOKUP, KeyW'(20));
    send_req(REQ_DELETE, '0);
    send_req(REQ_DELETE, '0);
    send_req(REQ_INSERT, KeyW'(30));
    // Random: phases that fill the pool hard, drain it, or mix.
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) p = $urandom_range(0, 2);
      burst = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: send_req(p == 0 ? REQ_INSERT : REQ_DELETE, pick_key(), burst);
        3, 4, 5: send_req(p == 1 ? REQ_DELETE : REQ_INSERT, pick_key(), burst);
        6, 7, 8: send_req(REQ_LOOKUP, pick_key(), burst);
        default: send_req(req_e'($urandom_range(0, 3)), pick_key(), burst);
      endcase
    end
    push <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d requests: %0d done/found, %0d duplicate, %0d absent, %0d pool full",
             beats_in, sb.n_done, sb.n_present, sb.n_absent, sb.n_full);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("chained_hash_set verification clean");
    end else begin
      $display("chained_hash_set verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
